>>> rtl/dgpm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dgpm_pkg
// Shared types and constants of the dual-gain pixel mixer.
// ---------------------------------------------------------------------------
package dgpm_pkg;

    typedef enum logic [1:0] {
        FMT_RGBA = 2'd0,
        FMT_GRAY = 2'd1,
        FMT_UYVY = 2'd2
    } pix_fmt_t;

    typedef enum logic [1:0] {
        REG_LEFT_GAIN    = 2'd0,
        REG_RIGHT_GAIN   = 2'd1,
        REG_PIXEL_FORMAT = 2'd2
    } reg_idx_t;

    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LANES   = 4;

    localparam logic [7:0] LEFT_GAIN_RST  = 8'd128;
    localparam logic [7:0] RIGHT_GAIN_RST = 8'd128;
    localparam logic [7:0] CHROMA_OFFSET  = 8'd128;
    localparam logic [7:0] BYTE_MAX       = 8'd255;

    typedef logic [BYTE_W-1:0] byte_lane_t;

endpackage : dgpm_pkg
`default_nettype wire

>>> rtl/dual_gain_pixel_mixer_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dual_gain_pixel_mixer_top
// Blends four-lane left and right words, each scaled by its own 8-bit gain
// (256 would be unity), in RGBA (left alpha passed), gray or UYVY format.
// ---------------------------------------------------------------------------
// One beat in, one beat out. The block takes a beat every cycle unless
// output back-pressure stalls it: one input register, then eight 8x8
// multipliers with the add, shift and clamp logic, then the result
// register. Back-pressure on the output stalls the input only when both
// registers are full. Gains and format come from the APB registers (left
// gain at 0x0, right gain at 0x4, format at 0x8); the user must change them
// only while no beat is in flight, and the block itself does not enforce it.
// ---------------------------------------------------------------------------
module dual_gain_pixel_mixer_top
    import dgpm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,

    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        left_byte0,
    input  wire logic [7:0]        left_byte1,
    input  wire logic [7:0]        left_byte2,
    input  wire logic [7:0]        left_byte3,
    input  wire logic [7:0]        right_byte0,
    input  wire logic [7:0]        right_byte1,
    input  wire logic [7:0]        right_byte2,
    input  wire logic [7:0]        right_byte3,

    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             mixed_byte0,
    output logic [7:0]             mixed_byte1,
    output logic [7:0]             mixed_byte2,
    output logic [7:0]             mixed_byte3
);

    logic [7:0]  left_gain_reg;
    logic [7:0]  right_gain_reg;
    logic [1:0]  pixel_format_reg;
    logic        cfg_write;
    reg_idx_t    cfg_idx;

    logic        in_valid_reg;
    logic        out_valid_reg;
    logic        in_load;
    logic        out_load;

    byte_lane_t  left_reg  [LANES];
    byte_lane_t  right_reg [LANES];
    byte_lane_t  mixed_reg [LANES];
    byte_lane_t  mixed_next[LANES];

    // ---------------------------------------------------------------- APB
    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_gain_reg    <= LEFT_GAIN_RST;
            right_gain_reg   <= RIGHT_GAIN_RST;
            pixel_format_reg <= FMT_RGBA;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_LEFT_GAIN:    left_gain_reg    <= pwdata[7:0];
                REG_RIGHT_GAIN:   right_gain_reg   <= pwdata[7:0];
                REG_PIXEL_FORMAT: pixel_format_reg <= pwdata[1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (cfg_idx)
            REG_LEFT_GAIN:    prdata[7:0] = left_gain_reg;
            REG_RIGHT_GAIN:   prdata[7:0] = right_gain_reg;
            REG_PIXEL_FORMAT: prdata[1:0] = pixel_format_reg;
            default:          prdata      = '0;
        endcase
    end

    // ---------------------------------------------------------- datapath
    function automatic byte_lane_t mix_separate(byte_lane_t a, byte_lane_t b,
                                                logic [7:0] gl, logic [7:0] gr);
        logic [15:0] pl;
        logic [15:0] pr;
        logic [8:0]  sum;
        pl  = a * gl;
        pr  = b * gr;
        sum = {1'b0, pl[15:8]} + {1'b0, pr[15:8]};
        return sum[8] ? BYTE_MAX : sum[7:0];
    endfunction

    function automatic byte_lane_t mix_luma(byte_lane_t a, byte_lane_t b,
                                            logic [7:0] gl, logic [7:0] gr);
        logic [15:0] pl;
        logic [15:0] pr;
        logic [16:0] sum;
        pl  = a * gl;
        pr  = b * gr;
        sum = {1'b0, pl} + {1'b0, pr};
        return sum[16] ? BYTE_MAX : sum[15:8];
    endfunction

    function automatic byte_lane_t mix_chroma(byte_lane_t a, byte_lane_t b,
                                              logic [7:0] gl, logic [7:0] gr);
        logic [15:0]        pl;
        logic [15:0]        pr;
        logic [16:0]        sum;
        logic [15:0]        bias;
        logic signed [18:0] s;
        logic signed [10:0] q;
        pl   = a * gl;
        pr   = b * gr;
        sum  = {1'b0, pl} + {1'b0, pr};
        bias = {({1'b0, gl} + {1'b0, gr}), 7'd0};
        s    = $signed({2'b00, sum}) - $signed({3'b000, bias});
        q    = $signed(s[18:8]) + $signed({3'b000, CHROMA_OFFSET});
        if (q[10])
            return '0;
        else if (q[9:8] != 2'b00)
            return BYTE_MAX;
        else
            return q[7:0];
    endfunction

    always_comb
    begin
        case (pixel_format_reg)
            FMT_RGBA:
            begin
                for (int i = 0; i < LANES - 1; i++)
                    mixed_next[i] = mix_separate(left_reg[i], right_reg[i],
                                                 left_gain_reg, right_gain_reg);
                mixed_next[LANES-1] = left_reg[LANES-1];
            end
            FMT_UYVY:
            begin
                mixed_next[0] = mix_chroma(left_reg[0], right_reg[0],
                                           left_gain_reg, right_gain_reg);
                mixed_next[1] = mix_luma(left_reg[1], right_reg[1],
                                         left_gain_reg, right_gain_reg);
                mixed_next[2] = mix_chroma(left_reg[2], right_reg[2],
                                           left_gain_reg, right_gain_reg);
                mixed_next[3] = mix_luma(left_reg[3], right_reg[3],
                                         left_gain_reg, right_gain_reg);
            end
            default:
            begin
                for (int i = 0; i < LANES; i++)
                    mixed_next[i] = mix_separate(left_reg[i], right_reg[i],
                                                 left_gain_reg, right_gain_reg);
            end
        endcase
    end

    // ----------------------------------------------------------- control
    assign out_load = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || out_load;
    assign in_load  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            left_reg[0]  <= left_byte0;
            left_reg[1]  <= left_byte1;
            left_reg[2]  <= left_byte2;
            left_reg[3]  <= left_byte3;
            right_reg[0] <= right_byte0;
            right_reg[1] <= right_byte1;
            right_reg[2] <= right_byte2;
            right_reg[3] <= right_byte3;
        end
        if (out_load)
            mixed_reg <= mixed_next;
    end

    assign out_valid   = out_valid_reg;
    assign mixed_byte0 = mixed_reg[0];
    assign mixed_byte1 = mixed_reg[1];
    assign mixed_byte2 = mixed_reg[2];
    assign mixed_byte3 = mixed_reg[3];

    // -------------------------------------------------------- assertions
    a_load_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("result register not filled after load");

    a_empty_takes_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !in_ready) |=> in_valid_reg)
        else $error("stalled beat dropped from input register");

    a_alpha_passes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && pixel_format_reg == FMT_RGBA) |=>
        mixed_reg[3] == $past(left_reg[3]))
        else $error("alpha lane not passed through");

endmodule : dual_gain_pixel_mixer_top
`default_nettype wire
